// ===== rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // length counter and capacity register
  localparam int LengthBits = 12;
  localparam int CapWidth   = 13;
  localparam logic [CapWidth-1:0] CapTop = CapWidth'(1 << LengthBits);
  localparam logic [CapWidth-1:0] CapReset = 13'd64;

  // job queue between front and back
  localparam int QueuePtrBits = 2;
  localparam int QueueDepth   = 1 << QueuePtrBits;

  // \u escape takes this many bytes
  localparam logic [2:0] HexDigits = 3'd4;

  // character codes
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChQmark  = 8'h3F;

  localparam logic [15:0] SurrLo = 16'hD800;
  localparam logic [15:0] SurrHi = 16'hDFFF;

  localparam logic [7:0] Utf8Cont  = 8'h80;
  localparam logic [7:0] Utf8Lead2 = 8'hC0;
  localparam logic [7:0] Utf8Lead3 = 8'hE0;
  localparam logic [7:0] Utf8Mask3 = 8'hF0;

  typedef enum logic [2:0] {
    PH_NORMAL,
    PH_ESCAPE,
    PH_HEX,
    PH_UTF8,
    PH_DONE
  } phase_t;

  // one accepted byte's worth of results: up to four data bytes, then maybe an end item
  typedef struct packed {
    logic [3:0][7:0]       bytes;
    logic [2:0]            nbytes;
    logic                  has_end;
    logic [LengthBits-1:0] length;
  } job_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      n;
  } enc_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } hex_t;

  function automatic enc_t enc_utf8(input logic [15:0] cp);
    enc_t e;
    e.bytes = '0;
    if (cp < 16'h0080) begin
      e.n = 2'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp < 16'h0800) begin
      e.n = 2'd2;
      e.bytes[0] = Utf8Lead2 | {3'b000, cp[10:6]};
      e.bytes[1] = Utf8Cont | {2'b00, cp[5:0]};
    end else begin
      e.n = 2'd3;
      e.bytes[0] = Utf8Lead3 | {4'b0000, cp[15:12]};
      e.bytes[1] = Utf8Cont | {2'b00, cp[11:6]};
      e.bytes[2] = Utf8Cont | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] n;
    if (lead < Utf8Cont) n = 3'd1;
    else if ((lead & Utf8Lead3) == Utf8Lead2) n = 3'd2;
    else if ((lead & Utf8Mask3) == Utf8Lead3) n = 3'd3;
    else n = 3'd4;
    return n;
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) h.val = 4'(b - 8'h30);
    else if (b >= 8'h61 && b <= 8'h66) h.val = 4'(b - 8'h57);
    else if (b >= 8'h41 && b <= 8'h46) h.val = 4'(b - 8'h37);
    else h.valid = 1'b0;
    return h;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/jsu_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_byte,
  input  wire logic                           in_last,
  input  wire logic [jsu_pkg::CapWidth-1:0]   capacity,
  input  wire logic                           q_full,
  output logic                                push,
  output jsu_pkg::job_t                       job
);

  jsu_pkg::phase_t phase, phase_next;
  logic [15:0] hex_value, hex_value_next;
  logic [2:0]  hex_count, hex_count_next;
  logic        hex_stopped, hex_stopped_next;
  logic [3:0][7:0] seq_b, seq_b_next;
  logic [2:0]  seq_needed, seq_needed_next;
  logic [jsu_pkg::LengthBits-1:0] written_count, written_count_next;

  logic [jsu_pkg::CapWidth-1:0] cap_lim;
  logic [4:0]      fit_v;
  logic            accept;
  logic [2:0]      emit_n;
  logic [3:0][7:0] emit_b;
  logic            fin;

  jsu_pkg::hex_t hd;
  logic [15:0]   hex_upd;
  logic [15:0]   code;
  jsu_pkg::enc_t enc;
  logic          fit_code;
  logic [7:0]    esc_cp;
  logic [2:0]    seq_total;
  logic [2:0]    seq_idx;
  logic [2:0]    cnt_inc;
  logic [2:0]    lead_n;
  logic [3:0][7:0] seq_ins;

  assign accept  = in_valid && in_ready;
  assign cap_lim = (capacity > jsu_pkg::CapTop) ? jsu_pkg::CapTop : capacity;

  // room check for 0..4 more bytes
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      fit_v[i] = ({1'b0, written_count} + jsu_pkg::CapWidth'(i)) < cap_lim;
    end
  end

  always_comb begin
    hd = jsu_pkg::hex_digit(in_byte);
    hex_upd = (!hex_stopped && hd.valid) ? {hex_value[11:0], hd.val} : hex_value;
    esc_cp = (in_byte == jsu_pkg::ChN) ? jsu_pkg::ChLf :
             (in_byte == jsu_pkg::ChT) ? jsu_pkg::ChTab : in_byte;
    if (phase == jsu_pkg::PH_HEX) begin
      code = (hex_upd >= jsu_pkg::SurrLo && hex_upd <= jsu_pkg::SurrHi) ?
             {8'h00, jsu_pkg::ChQmark} : hex_upd;
    end else begin
      code = (in_byte == jsu_pkg::ChU) ? 16'h0000 : {8'h00, esc_cp};
    end
    enc = jsu_pkg::enc_utf8(code);
    fit_code = fit_v[{1'b0, enc.n}];
    seq_total = jsu_pkg::seq_len(seq_b[0]);
    seq_idx = seq_total - seq_needed;
    cnt_inc = hex_count + 3'd1;
    lead_n = jsu_pkg::seq_len(in_byte);
    seq_ins = seq_b;
    seq_ins[seq_idx[1:0]] = in_byte;
  end

  // next state
  always_comb begin
    phase_next = phase;
    hex_value_next = hex_value;
    hex_count_next = hex_count;
    hex_stopped_next = hex_stopped;
    seq_b_next = seq_b;
    seq_needed_next = seq_needed;
    emit_n = 3'd0;
    emit_b = '0;
    fin = 1'b0;
    unique case (phase)
      jsu_pkg::PH_DONE: begin
        if (in_last) phase_next = jsu_pkg::PH_NORMAL;
      end
      jsu_pkg::PH_ESCAPE: begin
        if (in_byte == jsu_pkg::ChNul) begin
          if (fit_v[1]) begin
            emit_n = 3'd1;
            emit_b[0] = jsu_pkg::ChBslash;
          end
          fin = 1'b1;
        end else if (in_byte == jsu_pkg::ChU) begin
          phase_next = jsu_pkg::PH_HEX;
          hex_value_next = '0;
          hex_count_next = '0;
          hex_stopped_next = 1'b0;
          if (in_last) begin
            if (fit_code) begin
              emit_n = {1'b0, enc.n};
              emit_b = {8'h00, enc.bytes};
            end
            fin = 1'b1;
          end
        end else begin
          phase_next = jsu_pkg::PH_NORMAL;
          if (fit_code) begin
            emit_n = {1'b0, enc.n};
            emit_b = {8'h00, enc.bytes};
          end
          fin = !fit_code || in_last;
        end
      end
      jsu_pkg::PH_HEX: begin
        if (in_byte == jsu_pkg::ChNul) begin
          if (fit_code) begin
            emit_n = {1'b0, enc.n};
            emit_b = {8'h00, enc.bytes};
          end
          fin = 1'b1;
        end else begin
          hex_value_next = hex_upd;
          hex_stopped_next = hex_stopped || !hd.valid;
          hex_count_next = cnt_inc;
          if (cnt_inc >= jsu_pkg::HexDigits || in_last) begin
            phase_next = jsu_pkg::PH_NORMAL;
            hex_value_next = '0;
            hex_count_next = '0;
            hex_stopped_next = 1'b0;
            if (fit_code) begin
              emit_n = {1'b0, enc.n};
              emit_b = {8'h00, enc.bytes};
            end
            fin = !fit_code || in_last;
          end
        end
      end
      jsu_pkg::PH_UTF8: begin
        if (in_byte == jsu_pkg::ChNul || seq_needed == 3'd0 || seq_idx >= 3'd4) begin
          fin = 1'b1;
        end else begin
          seq_b_next = seq_ins;
          seq_needed_next = seq_needed - 3'd1;
          if (seq_needed == 3'd1) begin
            phase_next = jsu_pkg::PH_NORMAL;
            seq_b_next = '0;
            if (!fit_v[seq_total]) begin
              fin = 1'b1;
            end else begin
              emit_n = seq_total;
              emit_b = seq_ins;
              fin = in_last;
            end
          end else begin
            fin = in_last;
          end
        end
      end
      default: begin
        phase_next = jsu_pkg::PH_NORMAL;
        if (in_byte == jsu_pkg::ChQuote || in_byte == jsu_pkg::ChNul) begin
          fin = 1'b1;
        end else if (in_byte == jsu_pkg::ChBslash) begin
          if (in_last) begin
            if (fit_v[1]) begin
              emit_n = 3'd1;
              emit_b[0] = jsu_pkg::ChBslash;
            end
            fin = 1'b1;
          end else begin
            phase_next = jsu_pkg::PH_ESCAPE;
          end
        end else if (!fit_v[lead_n]) begin
          fin = 1'b1;
        end else if (lead_n == 3'd1) begin
          emit_n = 3'd1;
          emit_b[0] = in_byte;
          fin = in_last;
        end else begin
          seq_b_next = {24'h000000, in_byte};
          seq_needed_next = lead_n - 3'd1;
          phase_next = jsu_pkg::PH_UTF8;
          fin = in_last;
        end
      end
    endcase
    if (fin) begin
      phase_next = in_last ? jsu_pkg::PH_NORMAL : jsu_pkg::PH_DONE;
      hex_value_next = '0;
      hex_count_next = '0;
      hex_stopped_next = 1'b0;
      seq_b_next = '0;
      seq_needed_next = '0;
      written_count_next = '0;
    end else begin
      written_count_next = written_count + jsu_pkg::LengthBits'(emit_n);
    end
  end

  // outputs
  always_comb begin
    in_ready = !q_full;
    push = accept && (emit_n != 3'd0 || fin);
    job.bytes = emit_b;
    job.nbytes = emit_n;
    job.has_end = fin;
    job.length = written_count + jsu_pkg::LengthBits'(emit_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= jsu_pkg::PH_NORMAL;
      hex_value <= '0;
      hex_count <= '0;
      hex_stopped <= 1'b0;
      seq_b <= '0;
      seq_needed <= '0;
      written_count <= '0;
    end else if (accept) begin
      phase <= phase_next;
      hex_value <= hex_value_next;
      hex_count <= hex_count_next;
      hex_stopped <= hex_stopped_next;
      seq_b <= seq_b_next;
      seq_needed <= seq_needed_next;
      written_count <= written_count_next;
    end
  end

  a_utf8_pending: assert property (@(posedge clk) disable iff (rst)
    phase == jsu_pkg::PH_UTF8 |-> seq_needed != 3'd0 && seq_needed < 3'd4)
    else $error("utf8 phase without pending continuation bytes");

  a_hex_count: assert property (@(posedge clk) disable iff (rst)
    phase == jsu_pkg::PH_HEX |-> hex_count < jsu_pkg::HexDigits)
    else $error("hex escape ran past four bytes");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && fin |=> written_count == '0 && phase != jsu_pkg::PH_UTF8)
    else $error("string end did not clear length");

endmodule

`default_nettype wire

// ===== rtl/jsu_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire jsu_pkg::job_t push_job,
  output logic               full,
  input  wire logic          pop,
  output jsu_pkg::job_t      head,
  output logic               empty
);

  jsu_pkg::job_t slots [jsu_pkg::QueueDepth];
  logic [jsu_pkg::QueuePtrBits-1:0] wr_ptr, rd_ptr;
  logic [jsu_pkg::QueuePtrBits:0]   count;
  logic do_push, do_pop;

  assign full    = count == (jsu_pkg::QueuePtrBits+1)'(jsu_pkg::QueueDepth);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + jsu_pkg::QueuePtrBits'(1);
      if (do_pop) rd_ptr <= rd_ptr + jsu_pkg::QueuePtrBits'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (jsu_pkg::QueuePtrBits+1)'(1);
        2'b01:   count <= count - (jsu_pkg::QueuePtrBits+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/jsu_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire jsu_pkg::job_t                     head,
  input  wire logic                              empty,
  output logic                                   pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [7:0]                             out_byte,
  output logic                                   out_end,
  output logic [jsu_pkg::LengthBits-1:0]         out_len
);

  logic [2:0] pos;
  logic adv, take, is_byte, last;

  assign adv     = !out_valid || out_ready;
  assign take    = adv && !empty;
  assign is_byte = pos < head.nbytes;
  assign last    = is_byte ? (pos == head.nbytes - 3'd1 && !head.has_end) : 1'b1;
  assign pop     = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos <= '0;
    end else if (adv) begin
      out_valid <= !empty;
      if (take) pos <= last ? 3'd0 : pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= is_byte ? head.bytes[pos[1:0]] : 8'h00;
      out_end <= !is_byte;
      out_len <= is_byte ? '0 : head.length;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/json_string_unescape_utf8_unit.sv =====
// path: an accepted byte's results are written into the job queue, then pass through the
//   back's output register before they appear on the output
// throughput: one input byte per cycle while each byte yields at most one item and m_tready
//   stays high; a byte that yields more items holds the output side until all have gone out,
//   and a four-job queue lets the input keep running during such bursts
// reset: synchronous rst clears decoder state, queue and output valid; capacity returns to 64
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream of raw string text bytes
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,      // [7:0] in_byte
  input  wire logic        s_tlast,      // end_of_buffer
  // decoded output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,      // [7:0] out_byte, [19:8] out_length, [23:20] zero
  output logic             m_tlast,      // is_end
  // capacity register write
  input  wire logic        cfg_wr_en,
  input  wire logic [12:0] cfg_wr_data
);

  // output buffer capacity including terminator
  logic [jsu_pkg::CapWidth-1:0] out_capacity;

  // front to queue
  logic          push;
  jsu_pkg::job_t push_job;
  logic          q_full;

  // queue to back
  jsu_pkg::job_t head;
  logic          q_empty;
  logic          pop;

  logic [7:0]                     out_byte;
  logic [jsu_pkg::LengthBits-1:0] out_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= jsu_pkg::CapReset;
    end else if (cfg_wr_en) begin
      out_capacity <= cfg_wr_data;
    end
  end

  // front: escape and utf8 decode, one byte per transfer, builds a job per byte that yields output or ends the string
  jsu_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_byte  (s_tdata),
    .in_last  (s_tlast),
    .capacity (out_capacity),
    .q_full   (q_full),
    .push     (push),
    .job      (push_job)
  );

  // short job queue decouples decode from output draining
  jsu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // back: splits jobs into single output transfers through a register
  jsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (out_byte),
    .out_end   (m_tlast),
    .out_len   (out_len)
  );

  assign m_tdata = {4'h0, out_len, out_byte};

  a_data_no_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[19:8] == 12'd0)
    else $error("data transfer carries a length");

  a_end_no_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[7:0] == 8'h00)
    else $error("end transfer carries a data byte");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into full queue");

endmodule

`default_nettype wire
